// ===== design/nearest_value_binary_search_defines.svh =====
// Assertion macros for the nearest-value search block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef NEAREST_VALUE_BINARY_SEARCH_DEFINES_SVH
`define NEAREST_VALUE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication
`define NVBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NVBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nvbs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the nearest-value search block. No dependencies.
package nvbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 10;
    localparam int FIELD_W = 32;

    localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        RD_ZERO     = 3'd0,
        RD_LAST     = 3'd1,
        RD_MID      = 3'd2,
        RD_NEIGH_LO = 3'd3,
        RD_NEIGH_HI = 3'd4
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_FIRST = 3'd0,
        RES_LAST  = 3'd1,
        RES_HIT   = 3'd2,
        RES_END   = 3'd3,
        RES_TIE   = 3'd4
    } t_res_sel;

    typedef struct packed {
        logic     load;       // capture target and count, reset bounds
        logic     wr_en;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     mark_probe; // keep probed value and direction
        logic     step;       // narrow bounds
        logic     set_mid;
        logic     diff_en;
        logic     res_en;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic le;
        logic ge;
        logic eq;
        logic lt;
        logic nb_in;     // target strictly between probe and neighbor
        logic mid_zero;
        logic mid_last;
        logic cont;      // bounds still open after a step
    } t_dp_status;

endpackage

// ===== design/nvbs_datapath.sv =====
// Table memory, bounds, compare and result registers of the search block.
// Depends on nvbs_pkg; driven by nvbs_controller commands.
module nvbs_datapath #(
    parameter int TABLE_DEPTH = nvbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = nvbs_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nvbs_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [nvbs_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [nvbs_pkg::FIELD_W-1:0] i_entry_value,
    input  logic signed [nvbs_pkg::FIELD_W-1:0] i_target_value,
    input  nvbs_pkg::t_dp_cmd                   i_cmd,
    output nvbs_pkg::t_dp_status                o_status,
    output logic [nvbs_pkg::IDX_W-1:0]          o_nearest_index,
    output logic                                o_exact_hit
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > nvbs_pkg::CFG_W) ? CW : nvbs_pkg::CFG_W;
    localparam int VB = VALUE_BITS;

    logic signed [VB-1:0] r_mem [TABLE_DEPTH];
    logic signed [VB-1:0] r_rdata;
    logic [nvbs_pkg::CFG_W-1:0] r_count;
    logic signed [VB-1:0] r_t;
    logic signed [VB-1:0] r_m;
    logic                 r_dir;    // 1: target below the probe
    logic [CW-1:0] r_n, r_l, r_r;
    logic [AW-1:0] r_mid, r_li, r_res_idx;
    logic [VB-1:0] r_d1, r_d2;
    logic          r_res_exact;
    logic [nvbs_pkg::IDX_W-1:0] r_out_idx;
    logic                       r_out_exact;

    logic [NW-1:0] cnt_ext, n_sat;
    logic [CW-1:0] step_l, step_r;
    logic [CW-1:0] nl, nr;
    logic [CW:0]   bound_sum;
    logic [AW-1:0] mid_n, raddr;
    logic          wr_ok;
    logic signed [VB-1:0] dif_a, dif_b;
    logic signed [VB:0]   w_d1, w_d2;

    // effective count: zero reads as one, above depth saturates
    always_comb begin
        cnt_ext = NW'(r_count);
        if (cnt_ext == '0) begin
            n_sat = NW'(1);
        end else if (cnt_ext > NW'(TABLE_DEPTH)) begin
            n_sat = NW'(TABLE_DEPTH);
        end else begin
            n_sat = cnt_ext;
        end
    end

    // bounds after a step from registered state; next midpoint from them on a step, else from the held bounds
    always_comb begin
        if (r_dir) begin
            step_l = r_l;
            step_r = CW'(r_mid);
        end else begin
            step_l = CW'(r_mid) + CW'(1);
            step_r = r_r;
        end
        if (i_cmd.step) begin
            nl = step_l;
            nr = step_r;
        end else begin
            nl = r_l;
            nr = r_r;
        end
        bound_sum = {1'b0, nl} + {1'b0, nr};
        mid_n     = AW'(bound_sum >> 1);
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            nvbs_pkg::RD_ZERO:     raddr = '0;
            nvbs_pkg::RD_LAST:     raddr = AW'(r_n - CW'(1));
            nvbs_pkg::RD_MID:      raddr = mid_n;
            nvbs_pkg::RD_NEIGH_LO: raddr = r_mid - AW'(1);
            nvbs_pkg::RD_NEIGH_HI: raddr = r_mid + AW'(1);
            default:               raddr = '0;
        endcase
    end

    assign wr_ok = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            r_mem[AW'(i_entry_index)] <= VB'(i_entry_value);
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= nvbs_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // neighbor pair ordered low/high for the distance compare
    always_comb begin
        if (r_dir) begin
            dif_a = r_rdata;
            dif_b = r_m;
        end else begin
            dif_a = r_m;
            dif_b = r_rdata;
        end
        w_d1 = {r_t[VB-1], r_t} - {dif_a[VB-1], dif_a};
        w_d2 = {dif_b[VB-1], dif_b} - {r_t[VB-1], r_t};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t <= VB'(i_target_value);
            r_n <= CW'(n_sat);
            r_l <= '0;
            r_r <= CW'(n_sat);
        end
        if (i_cmd.mark_probe) begin
            r_m   <= r_rdata;
            r_dir <= (r_t < r_rdata);
        end
        if (i_cmd.step) begin
            r_l <= nl;
            r_r <= nr;
        end
        if (i_cmd.set_mid) begin
            r_mid <= mid_n;
        end
        if (i_cmd.diff_en) begin
            r_d1 <= w_d1[VB-1:0];
            r_d2 <= w_d2[VB-1:0];
            r_li <= r_dir ? (r_mid - AW'(1)) : r_mid;
        end
        if (i_cmd.res_en) begin
            unique case (i_cmd.res_sel)
                nvbs_pkg::RES_FIRST: begin
                    r_res_idx   <= '0;
                    r_res_exact <= (r_t == r_rdata);
                end
                nvbs_pkg::RES_LAST: begin
                    r_res_idx   <= AW'(r_n - CW'(1));
                    r_res_exact <= (r_t == r_rdata);
                end
                nvbs_pkg::RES_HIT: begin
                    r_res_idx   <= r_mid;
                    r_res_exact <= 1'b1;
                end
                nvbs_pkg::RES_END: begin
                    r_res_idx   <= r_mid;
                    r_res_exact <= 1'b0;
                end
                nvbs_pkg::RES_TIE: begin
                    // equal distance goes to the lower index
                    r_res_idx   <= (r_d1 <= r_d2) ? r_li : (r_li + AW'(1));
                    r_res_exact <= 1'b0;
                end
                default: begin
                    r_res_idx   <= r_mid;
                    r_res_exact <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_idx   <= nvbs_pkg::IDX_W'(r_res_idx);
            r_out_exact <= r_res_exact;
        end
    end

    always_comb begin
        o_status.le       = (r_t <= r_rdata);
        o_status.ge       = (r_t >= r_rdata);
        o_status.eq       = (r_t == r_rdata);
        o_status.lt       = (r_t < r_rdata);
        o_status.nb_in    = r_dir ? (r_t > r_rdata) : (r_t < r_rdata);
        o_status.mid_zero = (r_mid == '0);
        o_status.mid_last = (CW'(r_mid) == (r_n - CW'(1)));
        o_status.cont     = (step_l < step_r);
    end

    assign o_nearest_index = r_out_idx;
    assign o_exact_hit     = r_out_exact;

endmodule

// ===== design/nvbs_controller.sv =====
// Sequencer for the nearest-value search: end checks, halving probes,
// neighbor compare and result hand-off. Depends on nvbs_pkg.
module nvbs_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_cmd,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    input  nvbs_pkg::t_dp_status i_status,
    output nvbs_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIRST = 8'b0000_0010,
        S_LAST  = 8'b0000_0100,
        S_MCMP  = 8'b0000_1000,
        S_NCMP  = 8'b0001_0000,
        S_STEP  = 8'b0010_0000,
        S_TIE   = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state          = r_state;
        o_s_ready        = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.wr_en      = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = nvbs_pkg::RD_ZERO;
        o_cmd.mark_probe = 1'b0;
        o_cmd.step       = 1'b0;
        o_cmd.set_mid    = 1'b0;
        o_cmd.diff_en    = 1'b0;
        o_cmd.res_en     = 1'b0;
        o_cmd.res_sel    = nvbs_pkg::RES_END;
        o_cmd.out_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid && (i_s_cmd == nvbs_pkg::CMD_SEARCH)) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = nvbs_pkg::RD_ZERO;
                    n_state      = S_FIRST;
                end else if (i_s_valid) begin
                    o_cmd.wr_en = 1'b1;
                end
            end
            S_FIRST: begin
                if (i_status.le) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = nvbs_pkg::RES_FIRST;
                    n_state       = S_PUSH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = nvbs_pkg::RD_LAST;
                    n_state      = S_LAST;
                end
            end
            S_LAST: begin
                if (i_status.ge) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = nvbs_pkg::RES_LAST;
                    n_state       = S_PUSH;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = nvbs_pkg::RD_MID;
                    o_cmd.set_mid = 1'b1;
                    n_state       = S_MCMP;
                end
            end
            S_MCMP: begin
                o_cmd.mark_probe = 1'b1;
                if (i_status.eq) begin
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = nvbs_pkg::RES_HIT;
                    n_state       = S_PUSH;
                end else if (i_status.lt && i_status.mid_zero) begin
                    n_state = S_STEP;
                end else if (i_status.lt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = nvbs_pkg::RD_NEIGH_LO;
                    n_state      = S_NCMP;
                end else if (i_status.mid_last) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = nvbs_pkg::RD_NEIGH_HI;
                    n_state      = S_NCMP;
                end
            end
            S_NCMP, S_STEP: begin
                if (r_state == S_NCMP && i_status.nb_in) begin
                    o_cmd.diff_en = 1'b1;
                    n_state       = S_TIE;
                end else if (i_status.cont) begin
                    o_cmd.step    = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = nvbs_pkg::RD_MID;
                    o_cmd.set_mid = 1'b1;
                    n_state       = S_MCMP;
                end else begin
                    // halving ran out: report the last probe
                    o_cmd.step    = 1'b1;
                    o_cmd.res_en  = 1'b1;
                    o_cmd.res_sel = nvbs_pkg::RES_END;
                    n_state       = S_PUSH;
                end
            end
            S_TIE: begin
                o_cmd.res_en  = 1'b1;
                o_cmd.res_sel = nvbs_pkg::RES_TIE;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                if (!r_ovalid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_m_valid = r_ovalid;

endmodule

// ===== design/nearest_value_binary_search.sv =====
// Nearest-value search over an ascending table. Writes are taken back to back while idle.
// Search: accept and the end checks, then (unless an end decides) halving probes with a midpoint
// compare and, where needed, a neighbor compare, a distance compare if the target lies between, and
// the result load. The steps run in sequence over the single read port of the table memory.
// Reset (sync, active low) clears the sequencer and sets entry_count to 1024;
// the table is not cleared and holds undefined values until written.
`include "nearest_value_binary_search_defines.svh"

module nearest_value_binary_search #(
    parameter int TABLE_DEPTH = nvbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = nvbs_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [nvbs_pkg::CFG_W-1:0] i_cfg_wdata,   // entry_count
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [79:0]                i_s_tdata,     // entry_index, entry_value, target_value
    input  logic                       i_s_tuser,     // cmd
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [15:0]                o_m_tdata,     // nearest_index
    output logic                       o_m_tuser      // exact_hit
);

    nvbs_pkg::t_dp_cmd    dp_cmd;
    nvbs_pkg::t_dp_status dp_status;
    logic [nvbs_pkg::IDX_W-1:0] nearest_index;

    nvbs_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_s_cmd   (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    nvbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (i_s_tdata[9:0]),
        .i_entry_value   ($signed(i_s_tdata[41:10])),
        .i_target_value  ($signed(i_s_tdata[73:42])),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_nearest_index (nearest_index),
        .o_exact_hit     (o_m_tuser)
    );

    assign o_m_tdata = {6'd0, nearest_index};

    `NVBS_ASSERT_NEXT(a_busy_after_read, dp_cmd.rd_en, !o_s_tready, "read issued while idle")
    `NVBS_ASSERT_NEXT(a_search_blocks,
        i_s_tvalid && o_s_tready && (i_s_tuser == nvbs_pkg::CMD_SEARCH), !o_s_tready,
        "search accepted but sequencer stayed idle")
    `NVBS_ASSERT_NEXT(a_push_valid, dp_cmd.out_load, o_m_tvalid, "pushed result not offered")
    `NVBS_ASSERT_NOW(a_result_busy, dp_cmd.res_en, !o_s_tready && !dp_cmd.wr_en,
        "result written outside a search")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for nearest_value_binary_search: fills the table, runs
// searches under random stream idling and checks each result against a local predictor.
// Depends on nvbs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int FIELD_W         = nvbs_pkg::FIELD_W;
    localparam int IDX_W           = nvbs_pkg::IDX_W;
    localparam int CFG_W           = nvbs_pkg::CFG_W;
    localparam int TABLE_DEPTH_DEF = nvbs_pkg::TABLE_DEPTH_DEF;

    localparam int STALL_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int SETTLE      = 64;     // settle time after the last result in wait_idle
    localparam int GRID_SHIFT  = 22;     // full-depth table spacing, spans the value range
    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             hit;
    } t_nearest;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [79:0]        i_s_tdata = '0;     // entry_index, entry_value, target_value
    logic               i_s_tuser = 1'b0;   // cmd
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [15:0]        o_m_tdata;          // nearest_index
    logic               o_m_tuser;          // exact_hit

    // local copy of the table contents and the entry count
    logic signed [FIELD_W-1:0] stored_value [TABLE_DEPTH_DEF];
    bit                        written [TABLE_DEPTH_DEF];
    logic [CFG_W-1:0]          active_count = nvbs_pkg::COUNT_RESET;
    t_nearest                  pending_nearest [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;   // no idling on either side while set

    nearest_value_binary_search u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [FIELD_W-1:0] saturate(input longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[FIELD_W-1:0];
    endfunction

    // Same probe order as the block: end checks, then midpoint halving of [lo, hi).
    function automatic t_nearest find_nearest(input logic signed [FIELD_W-1:0] tgt);
        int       n;
        int       lo_b;
        int       hi_b;
        int       mid;
        bit       done;
        longint   tv;
        longint   mv;
        longint   nv;
        t_nearest r;
        n = (active_count == 0) ? 1 :
            (active_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(active_count);
        tv   = tgt;
        mid  = 0;
        done = 1'b0;
        lo_b = 0;
        hi_b = n;
        if (tv <= longint'(stored_value[0])) begin
            done = 1'b1;
        end else if (tv >= longint'(stored_value[n-1])) begin
            mid  = n - 1;
            done = 1'b1;
        end
        while (!done && lo_b < hi_b) begin
            mid = (lo_b + hi_b) / 2;
            mv  = stored_value[mid];
            if (mv == tv) begin
                done = 1'b1;
            end else if (tv < mv) begin
                if (mid > 0 && tv > longint'(stored_value[mid-1])) begin
                    nv = stored_value[mid-1];
                    if (tv - nv <= mv - tv)
                        mid = mid - 1;
                    done = 1'b1;
                end else begin
                    hi_b = mid;
                end
            end else begin
                if (mid < n - 1 && tv < longint'(stored_value[mid+1])) begin
                    nv = stored_value[mid+1];
                    if (tv - mv > nv - tv)
                        mid = mid + 1;
                    done = 1'b1;
                end else begin
                    lo_b = mid + 1;
                end
            end
        end
        r.index = mid[IDX_W-1:0];
        r.hit   = (stored_value[mid] == tgt);
        return r;
    endfunction

    // Target near the table contents: hits, off-by-one, midpoints (ties), spans, noise.
    function automatic logic signed [FIELD_W-1:0] choose_target(input int n);
        int     k;
        int     sel;
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint r;
        k   = $urandom_range(n - 1);
        sel = $urandom_range(99);
        a   = stored_value[k];
        if (sel < 30) begin
            r = a;
        end else if (sel < 50) begin
            r = $urandom_range(1) ? a + 1 : a - 1;
        end else if (sel < 70 && k + 1 < n) begin
            b = stored_value[k+1];
            r = (a + b) / 2;
        end else if (sel < 85) begin
            a  = stored_value[0];
            b  = stored_value[n-1];
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            r  = lo - 4 + longint'($urandom) % (hi - lo + 9);
        end else begin
            r = longint'($signed($urandom));
        end
        return saturate(r);
    endfunction

    // Full-depth table value at one position; entries are written only when a search reads them.
    function automatic longint grid_value(input int i);
        return longint'(VAL_MIN) + (longint'(i) << GRID_SHIFT);
    endfunction

    function automatic logic signed [FIELD_W-1:0] grid_target();
        int     k;
        int     sel;
        longint a;
        longint r;
        k   = $urandom_range(TABLE_DEPTH_DEF - 1);
        sel = $urandom_range(99);
        a   = grid_value(k);
        if (sel < 30) begin
            r = a;
        end else if (sel < 50) begin
            r = $urandom_range(1) ? a + 1 : a - 1;
        end else if (sel < 75) begin
            r = a + (longint'(1) << (GRID_SHIFT - 1));
        end else begin
            r = longint'($signed($urandom));
        end
        return saturate(r);
    endfunction

    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] pos,
                             input logic signed [FIELD_W-1:0] val,
                             input logic signed [FIELD_W-1:0] tgt);
        if (!steady && $urandom_range(99) < 37) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'b0, tgt, val, pos};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == nvbs_pkg::CMD_WRITE)
            stored_value[pos] = val;
        else
            pending_nearest.push_back(find_nearest(tgt));
    endtask

    task automatic search_for(input logic signed [FIELD_W-1:0] tgt);
        send_item(nvbs_pkg::CMD_SEARCH, IDX_W'($urandom), $urandom, tgt);
    endtask

    task automatic write_entry(input int pos, input logic signed [FIELD_W-1:0] val);
        send_item(nvbs_pkg::CMD_WRITE, pos[IDX_W-1:0], val, $urandom);
    endtask

    task automatic touch_entry(input int i);
        if (!written[i]) begin
            written[i] = 1'b1;
            write_entry(i, saturate(grid_value(i)));
        end
    endtask

    // Full-depth search: first write every entry on the probe path, then search.
    task automatic search_full(input logic signed [FIELD_W-1:0] tgt);
        int     lo_b;
        int     hi_b;
        int     mid;
        bit     done;
        longint tv;
        longint mv;
        tv   = tgt;
        lo_b = 0;
        hi_b = TABLE_DEPTH_DEF;
        touch_entry(0);
        touch_entry(TABLE_DEPTH_DEF - 1);
        done = (tv <= grid_value(0)) || (tv >= grid_value(TABLE_DEPTH_DEF - 1));
        while (!done && lo_b < hi_b) begin
            mid = (lo_b + hi_b) / 2;
            mv  = grid_value(mid);
            touch_entry(mid);
            if (mv == tv) begin
                done = 1'b1;
            end else if (tv < mv) begin
                if (mid > 0) begin
                    touch_entry(mid - 1);
                    done = (tv > grid_value(mid - 1));
                end
                if (!done)
                    hi_b = mid;
            end else begin
                if (mid < TABLE_DEPTH_DEF - 1) begin
                    touch_entry(mid + 1);
                    done = (tv < grid_value(mid + 1));
                end
                if (!done)
                    lo_b = mid + 1;
            end
        end
        search_for(tgt);
    endtask

    // Block idle: all results back, plus time for a trailing write transaction.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input int count);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count[CFG_W-1:0];
        @(posedge i_clk);
        active_count = count[CFG_W-1:0];
        i_cfg_we    <= 1'b0;
    endtask

    task automatic fill_ascending(input int n, input longint start, input int unsigned step_max);
        longint v;
        v = start;
        for (int i = 0; i < n; i++) begin
            v = saturate(v);
            write_entry(i, v[FIELD_W-1:0]);
            v = v + longint'($urandom_range(0, step_max));
        end
    endtask

    task automatic test_single_entry();
        set_entry_count(1);
        write_entry(0, 100);
        search_for(100);
        search_for(99);
        search_for(101);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        write_entry(0, VAL_MIN);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        // a count of zero behaves as one entry
        set_entry_count(0);
        search_for(0);
        search_for(VAL_MIN);
    endtask

    task automatic test_end_and_tie();
        set_entry_count(4);
        write_entry(0, VAL_MIN);
        write_entry(1, -10);
        write_entry(2, 10);
        write_entry(3, VAL_MAX);
        write_entry(TABLE_DEPTH_DEF - 1, VAL_MAX);
        search_for(0);          // equal distance to -10 and 10
        search_for(-10);
        search_for(5);
        search_for(-1);
        search_for(1);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        search_for(VAL_MAX - 1);
        search_for(VAL_MIN + 1);
    endtask

    task automatic test_full_depth();
        set_entry_count(TABLE_DEPTH_DEF);
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            written[i] = 1'b0;
        steady = 1'b1;
        repeat (8) search_full(grid_target());
        steady = 1'b0;
        search_full(VAL_MIN);
        search_full(VAL_MAX);
        repeat (4) search_full(grid_target());
        // counts above the table depth saturate
        set_entry_count(2047);
        repeat (6) search_full(grid_target());
    endtask

    task automatic test_random_tables();
        int          n;
        int unsigned step_max;
        longint      start;
        for (int phase = 0; phase < 7; phase++) begin
            steady = (phase >= 2 && phase < 4);
            n = ($urandom_range(3) == 0) ? $urandom_range(25, 96) : $urandom_range(1, 24);
            set_entry_count(n);
            case ($urandom_range(2))
                0: step_max = 3;
                1: step_max = 1000;
                default: step_max = 1 << 26;
            endcase
            case ($urandom_range(3))
                0: start = longint'(VAL_MIN);
                1: start = longint'($signed($urandom));
                default: start = longint'($urandom_range(0, 2000)) - 1000;
            endcase
            fill_ascending(n, start, step_max);
            // sometimes break the ordering
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) write_entry($urandom_range(n - 1), $urandom);
            repeat ($urandom_range(12, 28)) search_for(choose_target(n));
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= steady || ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin
        t_nearest want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_nearest.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: index %0d hit %0b",
                             o_m_tdata[IDX_W-1:0], o_m_tuser);
            end else begin
                want = pending_nearest.pop_front();
                if (o_m_tdata[IDX_W-1:0] !== want.index || o_m_tuser !== want.hit) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: index exp %0d got %0d, hit exp %0b got %0b",
                                 want.index, o_m_tdata[IDX_W-1:0], want.hit, o_m_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("nearest_value_binary_search test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_entry();
        test_end_and_tie();
        test_full_depth();
        test_random_tables();
        wait_idle();
        if (fail_count == 0 && pending_nearest.size() == 0)
            $display("nearest_value_binary_search test passed");
        else
            $display("nearest_value_binary_search test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/nvbs_pkg.sv
design/nvbs_datapath.sv
design/nvbs_controller.sv
design/nearest_value_binary_search.sv
sim/tb_top.sv
